// ===== sv/cpt_pkg.sv =====
package cpt_pkg;

	// default configuration of the bank
	localparam int DEF_TIMER_COUNT  = 4;
	localparam int DEF_ELAPSED_BITS = 16;
	localparam int TIMER_MAX        = 4;

	// field widths
	localparam int CTL_BITS   = 5;
	localparam int COUNT_BITS = 16;
	localparam int REST_BITS  = 10;
	localparam int THR_BITS   = 17;
	localparam int DIST_BITS  = 27;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 20;
	localparam int ROUTE_BITS     = 3;

	// bit positions inside one timer's control slice
	localparam int CTL_ENABLE  = 4;
	localparam int CTL_IRQ     = 3;
	localparam int CTL_CASCADE = 2;

	// sound routing bits
	localparam int ROUTE_MASTER = 0;
	localparam int ROUTE_FIFO_A = 1;
	localparam int ROUTE_FIFO_B = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMER_CONTROL = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELOAD_ZERO   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELOAD_ONE    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELOAD_TWO    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELOAD_THREE  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOUND_ROUTE   = 3'd5;

	// prescaler select codes
	localparam logic [1:0] PRE_DIV1    = 2'd0;
	localparam logic [1:0] PRE_DIV64   = 2'd1;
	localparam logic [1:0] PRE_DIV256  = 2'd2;
	localparam logic [1:0] PRE_DIV1024 = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DIST,
		ST_DONE
	} cpt_state_t;

	typedef struct packed {
		logic [TIMER_MAX-1:0][CTL_BITS-1:0]   control;
		logic [TIMER_MAX-1:0][COUNT_BITS-1:0] reload;
		logic [ROUTE_BITS-1:0]                route;
	} cpt_cfg_t;

	// prescaler select to shift amount
	function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
		logic [3:0] sh;
		case (sel)
			PRE_DIV64:   sh = 4'd6;
			PRE_DIV256:  sh = 4'd8;
			PRE_DIV1024: sh = 4'd10;
			default:     sh = 4'd0;
		endcase
		return sh;
	endfunction

endpackage

// ===== sv/cpt_regs.sv =====
module cpt_regs import cpt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cpt_cfg_t                  cfg
);

	cpt_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register write decode, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMER_CONTROL: cfg_q.control   <= cfg_data;
				REG_RELOAD_ZERO:   cfg_q.reload[0] <= cfg_data[COUNT_BITS-1:0];
				REG_RELOAD_ONE:    cfg_q.reload[1] <= cfg_data[COUNT_BITS-1:0];
				REG_RELOAD_TWO:    cfg_q.reload[2] <= cfg_data[COUNT_BITS-1:0];
				REG_RELOAD_THREE:  cfg_q.reload[3] <= cfg_data[COUNT_BITS-1:0];
				REG_SOUND_ROUTE:   cfg_q.route     <= cfg_data[ROUTE_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/cpt_div.sv =====
module cpt_div import cpt_pkg::*; #(
	parameter int NUM_BITS = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_BITS-1:0]   dividend,
	input  logic [THR_BITS-1:0]   divisor,
	output logic                  done,
	output logic [NUM_BITS-1:0]   quotient,
	output logic [COUNT_BITS-1:0] remainder
);

	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0]   quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [THR_BITS-1:0]   shifted;
	logic [THR_BITS-1:0]   diff;
	logic                  fits;

	// one restoring step: bring down the next dividend bit
	always_comb begin
		shifted = {rem_q, quo_q[NUM_BITS-1]};
		diff    = shifted - divisor;
		fits    = shifted >= divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
			rem_q <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== sv/cascaded_prescaled_timer_bank.sv =====
// per timer one load step, plus a bit-serial division when it overflows
// (NUM_BITS = max(ELAPSED_BITS,10)+1, 17 by default), then one distance step per timer
// for the irq distance and one to present the result. One item at a time; the next is
// taken once the result is registered. reset: arst_n clears registers, counts and remainders.
module cascaded_prescaled_timer_bank import cpt_pkg::*; #(
	parameter int TIMER_COUNT  = DEF_TIMER_COUNT,
	parameter int ELAPSED_BITS = DEF_ELAPSED_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [ELAPSED_BITS-1:0]   elapsed,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [TIMER_MAX-1:0]      irq_raised,
	output logic [COUNT_BITS-1:0]     wraps_zero,
	output logic [COUNT_BITS-1:0]     wraps_one,
	output logic [COUNT_BITS-1:0]     wraps_two,
	output logic [COUNT_BITS-1:0]     wraps_three,
	output logic [COUNT_BITS-1:0]     fifo_a_latches,
	output logic [COUNT_BITS-1:0]     fifo_b_latches,
	output logic [DIST_BITS-1:0]      irq_distance,
	output logic                      irq_none
);

	localparam int IW = ((ELAPSED_BITS > REST_BITS) ? ELAPSED_BITS : REST_BITS) + 1;
	localparam int CW = (IW > THR_BITS) ? IW : THR_BITS;
	localparam int TW = (TIMER_COUNT > 2) ? 2 : 1;

	function automatic logic [COUNT_BITS-1:0] sat16(input logic [IW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'hFFFF) ? 16'hFFFF : w[COUNT_BITS-1:0];
	endfunction

	cpt_cfg_t cfg;

	cpt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpt_state_t state_q, state_d;

	logic [TW-1:0]           idx_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [COUNT_BITS-1:0]   count_q [TIMER_COUNT];
	logic [REST_BITS-1:0]    rest_q  [TIMER_COUNT];
	logic [IW-1:0]           wraps_q [TIMER_COUNT];
	logic [IW-1:0]           carry_q;
	logic [TIMER_MAX-1:0]    irq_q;
	logic [DIST_BITS-1:0]    best_q;
	logic                    any_q;
	logic                    out_valid_q;
	logic [TIMER_MAX-1:0]    irq_out_q;
	logic [COUNT_BITS-1:0]   wraps_out_q [TIMER_MAX];
	logic [COUNT_BITS-1:0]   fifo_a_q;
	logic [COUNT_BITS-1:0]   fifo_b_q;
	logic [DIST_BITS-1:0]    dist_q;
	logic                    none_q;

	// current timer's view
	logic [CTL_BITS-1:0]   ctl;
	logic                  en;
	logic                  casc;
	logic [3:0]            sh;
	logic [COUNT_BITS-1:0] rl;
	logic [IW-1:0]         avail;
	logic [IW-1:0]         inc;
	logic [REST_BITS-1:0]  rest_new;
	logic [THR_BITS-1:0]   thr0;
	logic                  inc_ge;
	logic [IW-1:0]         rem_in;
	logic [THR_BITS-1:0]   divisor;
	logic                  last;
	logic [DIST_BITS-1:0]  need;
	logic [DIST_BITS-1:0]  cand;
	logic                  qualify;

	// fsm outputs
	logic item_take;
	logic div_start;
	logic out_load;

	logic                  div_done;
	logic [IW-1:0]         div_quo;
	logic [COUNT_BITS-1:0] div_rem;

	cpt_div #(.NUM_BITS(IW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rem_in),
		.divisor   (divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// per-timer decode, prescaler and first-overflow check
	always_comb begin
		ctl      = cfg.control[idx_q];
		en       = ctl[CTL_ENABLE];
		casc     = ctl[CTL_CASCADE] && (idx_q != '0);
		sh       = prescale_shift(ctl[1:0]);
		rl       = cfg.reload[idx_q];
		avail    = IW'(rest_q[idx_q]) + IW'(elapsed_q);
		inc      = casc ? carry_q : (avail >> sh);
		rest_new = avail[REST_BITS-1:0] & REST_BITS'((11'd1 << sh) - 11'd1);
		thr0     = 17'h10000 - {1'b0, count_q[idx_q]};
		inc_ge   = CW'(inc) >= CW'(thr0);
		rem_in   = IW'(CW'(inc) - CW'(thr0));
		divisor  = 17'h10000 - {1'b0, rl};
		last     = idx_q == TW'(TIMER_COUNT - 1);
	end

	// distance to the next irq of this timer
	always_comb begin
		need    = DIST_BITS'(17'h10000 - {1'b0, count_q[idx_q]}) << sh;
		cand    = (need > DIST_BITS'(rest_q[idx_q])) ? need - DIST_BITS'(rest_q[idx_q]) : '0;
		qualify = en && ctl[CTL_IRQ] && !casc;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (en && inc_ge) state_d = ST_DIV;
				else if (last)    state_d = ST_DIST;
			end
			ST_DIV: begin
				if (div_done) state_d = last ? ST_DIST : ST_LOAD;
			end
			ST_DIST: begin
				if (last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !result_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		item_stall = state_q != ST_IDLE;
		item_take  = (state_q == ST_IDLE) && item_valid;
		div_start  = (state_q == ST_LOAD) && en && inc_ge;
		out_load   = (state_q == ST_DONE) && (!out_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// timer state and step bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			carry_q <= '0;
			irq_q   <= '0;
			any_q   <= 1'b0;
			best_q  <= '0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				count_q[i] <= '0;
				rest_q[i]  <= '0;
				wraps_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						idx_q   <= '0;
						carry_q <= '0;
						irq_q   <= '0;
						any_q   <= 1'b0;
					end
				end
				ST_LOAD: begin
					if (!en) begin
						wraps_q[idx_q] <= '0;
						carry_q        <= '0;
					end else begin
						if (!casc) rest_q[idx_q] <= rest_new;
						if (!inc_ge) begin
							count_q[idx_q] <= count_q[idx_q] + inc[COUNT_BITS-1:0];
							wraps_q[idx_q] <= '0;
							carry_q        <= '0;
						end
					end
					if (!(en && inc_ge)) idx_q <= last ? '0 : idx_q + TW'(1);
				end
				ST_DIV: begin
					if (div_done) begin
						count_q[idx_q] <= rl + div_rem;
						wraps_q[idx_q] <= div_quo + IW'(1);
						carry_q        <= div_quo + IW'(1);
						irq_q[idx_q]   <= ctl[CTL_IRQ];
						idx_q          <= last ? '0 : idx_q + TW'(1);
					end
				end
				ST_DIST: begin
					if (qualify) begin
						any_q <= 1'b1;
						if (!any_q || cand < best_q) best_q <= cand;
					end
					idx_q <= last ? '0 : idx_q + TW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) elapsed_q <= elapsed;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar g = 0; g < TIMER_MAX; g++) begin : g_wraps
		if (g < TIMER_COUNT) begin : g_live
			always_ff @(posedge clk) begin
				if (out_load) wraps_out_q[g] <= sat16(wraps_q[g]);
			end
		end else begin : g_absent
			always_ff @(posedge clk) begin
				if (out_load) wraps_out_q[g] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			irq_out_q <= irq_q;
			fifo_a_q  <= cfg.route[ROUTE_MASTER] ? sat16(wraps_q[cfg.route[ROUTE_FIFO_A]]) : '0;
			fifo_b_q  <= cfg.route[ROUTE_MASTER] ? sat16(wraps_q[cfg.route[ROUTE_FIFO_B]]) : '0;
			dist_q    <= any_q ? best_q : '0;
			none_q    <= !any_q;
		end
	end

	assign result_valid   = out_valid_q;
	assign irq_raised     = irq_out_q;
	assign wraps_zero     = wraps_out_q[0];
	assign wraps_one      = wraps_out_q[1];
	assign wraps_two      = wraps_out_q[2];
	assign wraps_three    = wraps_out_q[3];
	assign fifo_a_latches = fifo_a_q;
	assign fifo_b_latches = fifo_b_q;
	assign irq_distance   = dist_q;
	assign irq_none       = none_q;

endmodule

// ===== tb/sv/cascaded_prescaled_timer_bank_test.sv =====
module cascaded_prescaled_timer_bank_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	localparam int NUM_TIMERS    = DEF_TIMER_COUNT;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD     = 400;

	typedef struct packed {
		logic [TIMER_MAX-1:0]  irq;
		logic [COUNT_BITS-1:0] w0;
		logic [COUNT_BITS-1:0] w1;
		logic [COUNT_BITS-1:0] w2;
		logic [COUNT_BITS-1:0] w3;
		logic [COUNT_BITS-1:0] fa;
		logic [COUNT_BITS-1:0] fb;
		logic [DIST_BITS-1:0]  irq_dist;
		logic                  none;
	} tick_report_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      item_valid;
	logic                      item_stall;
	logic [DEF_ELAPSED_BITS-1:0] elapsed;
	logic                      result_valid;
	logic                      result_stall;
	logic [TIMER_MAX-1:0]      irq_raised;
	logic [COUNT_BITS-1:0]     wraps_zero, wraps_one, wraps_two, wraps_three;
	logic [COUNT_BITS-1:0]     fifo_a_latches, fifo_b_latches;
	logic [DIST_BITS-1:0]      irq_distance;
	logic                      irq_none;

	// shadow of the bank: registers, counts and prescaler remainders
	logic [CFG_DATA_BITS-1:0]  ctl_shadow;
	logic [COUNT_BITS-1:0]     reload_shadow [TIMER_MAX];
	logic [ROUTE_BITS-1:0]     route_shadow;
	logic [COUNT_BITS-1:0]     count_shadow [TIMER_MAX];
	logic [REST_BITS-1:0]      rest_shadow [TIMER_MAX];

	tick_report_t pending_reports[$];
	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;
	int hold_left;
	logic hold_req;

	cascaded_prescaled_timer_bank u_top (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	function automatic int unsigned shift_for(input logic [1:0] sel);
		case (sel)
			PRE_DIV64:   return 6;
			PRE_DIV256:  return 8;
			PRE_DIV1024: return 10;
			default:     return 0;
		endcase
	endfunction

	function automatic logic [15:0] sat_count(input int unsigned v);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	// advance one timer by a tick count, returns exact overflow count
	function automatic int unsigned advance_timer(input int t, input int unsigned ticks);
		int unsigned wraps;
		int unsigned thr;
		wraps = 0;
		thr = 32'h10000 - count_shadow[t];
		if (ticks >= thr) begin
			wraps = 1;
			ticks -= thr;
			thr = 32'h10000 - reload_shadow[t];
			wraps += ticks / thr;
			ticks = ticks % thr;
			count_shadow[t] = reload_shadow[t];
		end
		count_shadow[t] = count_shadow[t] + ticks[15:0];
		return wraps;
	endfunction

	// one batch of elapsed cycles through all timers
	function automatic tick_report_t tick_bank(input logic [15:0] cycles);
		tick_report_t r;
		int unsigned wraps [TIMER_MAX];
		int unsigned carry, ticks, avail, sh, need, best;
		logic [4:0] c;
		bit any;
		r = '0;
		carry = 0;
		any = 0;
		best = 0;
		for (int t = 0; t < TIMER_MAX; t++) wraps[t] = 0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			c = ctl_shadow[5*t +: 5];
			if (!c[CTL_ENABLE]) begin
				carry = 0;
				continue;
			end
			if (c[CTL_CASCADE] && t > 0) begin
				ticks = carry;
			end else begin
				sh = shift_for(c[1:0]);
				avail = rest_shadow[t] + cycles;
				ticks = avail >> sh;
				rest_shadow[t] = REST_BITS'(avail & ((32'd1 << sh) - 1));
			end
			wraps[t] = (ticks != 0) ? advance_timer(t, ticks) : 0;
			carry = wraps[t];
			if (wraps[t] != 0 && c[CTL_IRQ]) r.irq[t] = 1'b1;
		end
		r.w0 = sat_count(wraps[0]);
		r.w1 = sat_count(wraps[1]);
		r.w2 = sat_count(wraps[2]);
		r.w3 = sat_count(wraps[3]);
		if (route_shadow[ROUTE_MASTER]) begin
			r.fa = sat_count(wraps[route_shadow[ROUTE_FIFO_A]]);
			r.fb = sat_count(wraps[route_shadow[ROUTE_FIFO_B]]);
		end
		// earliest irq from a free-running timer
		for (int t = 0; t < NUM_TIMERS; t++) begin
			c = ctl_shadow[5*t +: 5];
			if (!c[CTL_ENABLE] || !c[CTL_IRQ] || (c[CTL_CASCADE] && t > 0)) continue;
			need = (32'h10000 - count_shadow[t]) << shift_for(c[1:0]);
			need = (need > rest_shadow[t]) ? need - rest_shadow[t] : 0;
			if (!any || need < best) best = need;
			any = 1;
		end
		r.irq_dist = any ? best[DIST_BITS-1:0] : '0;
		r.none = !any;
		return r;
	endfunction

	// send one item, optionally idling first
	task automatic send_elapsed(input logic [15:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		elapsed <= v;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_reports.push_back(tick_bank(v));
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIMER_CONTROL: ctl_shadow = data;
			REG_RELOAD_ZERO:   reload_shadow[0] = data[15:0];
			REG_RELOAD_ONE:    reload_shadow[1] = data[15:0];
			REG_RELOAD_TWO:    reload_shadow[2] = data[15:0];
			REG_RELOAD_THREE:  reload_shadow[3] = data[15:0];
			REG_SOUND_ROUTE:   route_shadow = data[2:0];
			default: ;
		endcase
	endtask

	// wait until the bank is idle
	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reloads(input logic [15:0] r0, r1, r2, r3);
		write_reg(REG_RELOAD_ZERO, CFG_DATA_BITS'(r0));
		write_reg(REG_RELOAD_ONE, CFG_DATA_BITS'(r1));
		write_reg(REG_RELOAD_TWO, CFG_DATA_BITS'(r2));
		write_reg(REG_RELOAD_THREE, CFG_DATA_BITS'(r3));
	endtask

	function automatic logic [4:0] ctl(input bit en, irq, casc, input logic [1:0] sel);
		return {en, irq, casc, sel};
	endfunction

	// all timers off after reset
	task automatic test_reset_state;
		send_elapsed(16'h0000);
		send_elapsed(16'hFFFF);
		drain();
	endtask

	// each prescaler on a free-running timer
	task automatic test_prescalers;
		write_reg(REG_TIMER_CONTROL, {ctl(1, 1, 0, PRE_DIV1024), ctl(1, 1, 0, PRE_DIV256),
			ctl(1, 1, 0, PRE_DIV64), ctl(1, 1, 0, PRE_DIV1)});
		write_reloads(16'h0000, 16'hFF00, 16'hFFF0, 16'hFFFF);
		send_elapsed(16'hFFFF);
		send_elapsed(16'h0001);
		send_elapsed(16'h03FF);
		send_elapsed(16'h8000);
		send_elapsed(16'hFFFF);
		drain();
	endtask

	// cascade chain, cascade on timer 0 ignored, disabled cascaded link
	task automatic test_cascade;
		write_reloads(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
		write_reg(REG_TIMER_CONTROL, {ctl(1, 1, 1, PRE_DIV1), ctl(1, 1, 1, PRE_DIV1),
			ctl(1, 1, 1, PRE_DIV1), ctl(1, 1, 1, PRE_DIV1)});
		write_reg(REG_SOUND_ROUTE, 20'd3);
		send_elapsed(16'hFFFF);
		send_elapsed(16'hFFFF);
		send_elapsed(16'h0000);
		drain();
		write_reg(REG_TIMER_CONTROL, {ctl(1, 1, 1, PRE_DIV1), ctl(0, 1, 1, PRE_DIV1),
			ctl(1, 0, 1, PRE_DIV1), ctl(1, 1, 0, PRE_DIV1)});
		send_elapsed(16'hFFFF);
		send_elapsed(16'h1234);
		drain();
	endtask

	// remainder from a larger prescaler carried into a smaller one
	task automatic test_rest_carryover;
		write_reloads(16'hFFF0, 16'h0000, 16'h0000, 16'h0000);
		write_reg(REG_TIMER_CONTROL, {15'd0, ctl(1, 1, 0, PRE_DIV1024)});
		send_elapsed(16'd1000);
		drain();
		write_reg(REG_TIMER_CONTROL, {15'd0, ctl(1, 1, 0, PRE_DIV1)});
		send_elapsed(16'h0000);
		send_elapsed(16'hFFFF);
		drain();
		write_reg(REG_TIMER_CONTROL, {15'd0, ctl(1, 1, 0, PRE_DIV64)});
		send_elapsed(16'h003F);
		drain();
	endtask

	// every routing value, plus writes to unused indexes
	task automatic test_sound_route;
		write_reloads(16'hFFF0, 16'hFF00, 16'h0000, 16'h0000);
		write_reg(REG_TIMER_CONTROL, {10'd0, ctl(1, 0, 0, PRE_DIV1), ctl(1, 0, 0, PRE_DIV1)});
		for (int r = 0; r < 8; r++) begin
			write_reg(REG_SOUND_ROUTE, CFG_DATA_BITS'(r[2:0]));
			send_elapsed(16'h0F00);
			drain();
		end
		write_reg(3'd6, 20'hFFFFF);
		write_reg(3'd7, 20'h00000);
		send_elapsed(16'h0100);
		drain();
	endtask

	function automatic logic [15:0] pick_reload();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFF00 | 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_elapsed();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 1100));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// new random settings, then a batch of items
	task automatic run_random_phase(input int count);
		logic [CFG_DATA_BITS-1:0] c;
		c = CFG_DATA_BITS'($urandom_range(0, 20'hFFFFF));
		// mostly enabled timers so the chain does something
		for (int t = 0; t < NUM_TIMERS; t++)
			if ($urandom_range(0, 3) != 0) c[5*t + CTL_ENABLE] = 1'b1;
		write_reg(REG_TIMER_CONTROL, c);
		write_reloads(pick_reload(), pick_reload(), pick_reload(), pick_reload());
		write_reg(REG_SOUND_ROUTE, CFG_DATA_BITS'($urandom_range(0, 7)));
		for (int n = 0; n < count; n++) send_elapsed(pick_elapsed());
		drain();
	endtask

	task automatic test_random;
		for (int m = 0; m < 3; m++) begin
			send_idle_pct = (m == 0) ? 33 : (m == 1) ? 46 : 0;
			recv_idle_pct = (m == 0) ? 46 : (m == 1) ? 33 : 0;
			for (int p = 0; p < 6; p++) run_random_phase(100);
		end
	endtask

	// receiver holds off while items keep coming
	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_TIMER_CONTROL, {ctl(1, 1, 1, PRE_DIV1), ctl(1, 1, 0, PRE_DIV64),
			ctl(1, 1, 1, PRE_DIV1), ctl(1, 1, 0, PRE_DIV1)});
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (int n = 0; n < 8; n++) send_elapsed(pick_elapsed());
		drain();
	endtask

	// result checking
	always @(posedge clk) begin
		tick_report_t want;
		tick_report_t got;
		if (arst_n && result_valid && !result_stall) begin
			got = {irq_raised, wraps_zero, wraps_one, wraps_two, wraps_three,
				fifo_a_latches, fifo_b_latches, irq_distance, irq_none};
			if (pending_reports.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				want = pending_reports.pop_front();
				if (got.irq !== want.irq)
					report_mismatch($sformatf("irq_raised %h want %h", got.irq, want.irq));
				if (got.w0 !== want.w0)
					report_mismatch($sformatf("wraps_zero %h want %h", got.w0, want.w0));
				if (got.w1 !== want.w1)
					report_mismatch($sformatf("wraps_one %h want %h", got.w1, want.w1));
				if (got.w2 !== want.w2)
					report_mismatch($sformatf("wraps_two %h want %h", got.w2, want.w2));
				if (got.w3 !== want.w3)
					report_mismatch($sformatf("wraps_three %h want %h", got.w3, want.w3));
				if (got.fa !== want.fa)
					report_mismatch($sformatf("fifo_a_latches %h want %h", got.fa, want.fa));
				if (got.fb !== want.fb)
					report_mismatch($sformatf("fifo_b_latches %h want %h", got.fb, want.fb));
				if (got.irq_dist !== want.irq_dist)
					report_mismatch($sformatf("irq_distance %h want %h",
						got.irq_dist, want.irq_dist));
				if (got.none !== want.none)
					report_mismatch($sformatf("irq_none %b want %b", got.none, want.none));
			end
		end
	end

	// receiver stall, with a long counted hold on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// test sequence
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		elapsed = '0;
		result_stall = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		idle_cycles = 0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		ctl_shadow = '0;
		route_shadow = '0;
		for (int t = 0; t < TIMER_MAX; t++) begin
			reload_shadow[t] = '0;
			count_shadow[t] = '0;
			rest_shadow[t] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_prescalers();
		test_cascade();
		test_rest_carryover();
		test_sound_route();
		test_random();
		test_backpressure();
		drain();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
